/* rtl/ccpt_pkg.sv */
// ---------------------------------------------------------------------------
// Circumcircle point test package
// Shared widths, default parameters and word types for the circumcircle
// point test pipeline.
// ---------------------------------------------------------------------------
package ccpt_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int IN_BITS        = 16;
  localparam int OUT_BITS       = 32;
  localparam int QUO_BITS       = OUT_BITS + 1;

  typedef struct packed {
    logic signed [IN_BITS-1:0] first_x;
    logic signed [IN_BITS-1:0] first_y;
    logic signed [IN_BITS-1:0] second_x;
    logic signed [IN_BITS-1:0] second_y;
    logic signed [IN_BITS-1:0] third_x;
    logic signed [IN_BITS-1:0] third_y;
    logic signed [IN_BITS-1:0] query_x;
    logic signed [IN_BITS-1:0] query_y;
  } in_word_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] center_x;
    logic signed [OUT_BITS-1:0] center_y;
    logic                       inside_res;
    logic                       collinear;
    logic                       saturated;
  } out_word_t;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
    logic collinear;
    logic inside_res;
  } div_side_t;

endpackage

/* rtl/ccpt_div.sv */
// ---------------------------------------------------------------------------
// Circumcircle point test divider
// Pipelined restoring divider, one quotient bit per stage, dividing two
// numerators by a shared denominator with valid and side bits alongside.
// ---------------------------------------------------------------------------
module ccpt_div #(
  parameter int NW = 59,
  parameter int DW = 36,
  parameter int QB = 33
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  ccpt_pkg::div_side_t   side_i,
  input  logic [NW-1:0]         nx_i,
  input  logic [NW-1:0]         ny_i,
  input  logic [DW-1:0]         d_i,
  output logic                  valid_o,
  output ccpt_pkg::div_side_t   side_o,
  output logic [QB-1:0]         qx_o,
  output logic [QB-1:0]         qy_o
);
  import ccpt_pkg::*;

  localparam int WW = NW + QB;

  logic            v_q    [0:QB];
  div_side_t       side_q [0:QB];
  logic [NW-1:0]   rx_q   [0:QB];
  logic [NW-1:0]   ry_q   [0:QB];
  logic [DW-1:0]   d_q    [0:QB];
  logic [QB-1:0]   qx_q   [0:QB];
  logic [QB-1:0]   qy_q   [0:QB];

  always_comb begin
    v_q[0]    = valid_i;
    side_q[0] = side_i;
    rx_q[0]   = nx_i;
    ry_q[0]   = ny_i;
    d_q[0]    = d_i;
    qx_q[0]   = '0;
    qy_q[0]   = '0;
  end

  for (genvar j = 0; j < QB; j++) begin : g_stage
    localparam int B = QB - 1 - j;
    logic [WW-1:0] dsh;
    logic [WW-1:0] rxe;
    logic [WW-1:0] rye;
    logic          gex;
    logic          gey;

    always_comb begin
      dsh = WW'(d_q[j]) << B;
      rxe = WW'(rx_q[j]);
      rye = WW'(ry_q[j]);
      gex = rxe >= dsh;
      gey = rye >= dsh;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[j+1]  <= side_q[j];
      d_q[j+1]     <= d_q[j];
      rx_q[j+1]    <= gex ? NW'(rxe - dsh) : rx_q[j];
      ry_q[j+1]    <= gey ? NW'(rye - dsh) : ry_q[j];
      qx_q[j+1]    <= qx_q[j] | (QB'(gex) << B);
      qy_q[j+1]    <= qy_q[j] | (QB'(gey) << B);
    end
  end

  assign valid_o = v_q[QB];
  assign side_o  = side_q[QB];
  assign qx_o    = qx_q[QB];
  assign qy_o    = qy_q[QB];

endmodule

/* rtl/circumcircle_point_test_top.sv */
// ---------------------------------------------------------------------------
// Circumcircle point test
// Circumcenter of a triangle in fixed point and strict in-circle test of a
// query point, fully pipelined.
// ---------------------------------------------------------------------------
// A word with three vertices and a query point is taken on in_i at every
// clock edge where start_i is high and busy_o is low. busy_o is always low,
// so a new word can enter in every cycle.
// Each word gives one result word on res_o, shown for one cycle while
// res_valid_o is high. Between the accepted word and its result lie
// six arithmetic stages, one divider stage per quotient bit (33), and
// the output register.
// Throughput is one word per cycle at any mix of input gaps.
// The result receiver cannot stall; every result must be taken when shown.
// Reset clears all valid bits, so no result appears until words enter.
// ---------------------------------------------------------------------------
module circumcircle_point_test_top #(
  parameter int COORD_BITS = ccpt_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = ccpt_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  ccpt_pkg::in_word_t  in_i,
  output logic                res_valid_o,
  output ccpt_pkg::out_word_t res_o
);
  import ccpt_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int DXW  = C + 1;
  localparam int SQW  = 2 * C + 1;
  localparam int CW   = 2 * C + 1;
  localparam int PW   = 2 * C + 2;
  localparam int DETW = 2 * C + 3;
  localparam int DENW = 2 * C + 4;
  localparam int NPW  = 3 * C + 2;
  localparam int NXW  = 3 * C + 3;
  localparam int EPW  = 4 * C + 5;
  localparam int TPW  = 4 * C + 4;
  localparam int SW   = 4 * C + 7;
  localparam int NW   = NXW + FRAC_BITS;
  localparam int QB   = QUO_BITS;
  localparam int OW   = NW + QB;

  logic in_acc;
  assign busy_o = 1'b0;
  assign in_acc = start_i && !busy_o;

  logic signed [C-1:0] px, py, qx, qy, rx, ry, tx, ty;
  assign px = in_i.first_x[C-1:0];
  assign py = in_i.first_y[C-1:0];
  assign qx = in_i.second_x[C-1:0];
  assign qy = in_i.second_y[C-1:0];
  assign rx = in_i.third_x[C-1:0];
  assign ry = in_i.third_y[C-1:0];
  assign tx = in_i.query_x[C-1:0];
  assign ty = in_i.query_y[C-1:0];

  // Stage A: differences and squared norms.
  logic                  va_q;
  logic signed [DXW-1:0] dx1_a_q, dy1_a_q, dx2_a_q, dy2_a_q, tpx_a_q, tpy_a_q;
  logic signed [SQW-1:0] sp_a_q, sq_a_q, sr_a_q, st_a_q;

  always_ff @(posedge clk_i) begin
    dx1_a_q <= DXW'(qx) - DXW'(px);
    dy1_a_q <= DXW'(qy) - DXW'(py);
    dx2_a_q <= DXW'(rx) - DXW'(qx);
    dy2_a_q <= DXW'(ry) - DXW'(qy);
    tpx_a_q <= DXW'(tx) - DXW'(px);
    tpy_a_q <= DXW'(ty) - DXW'(py);
    sp_a_q  <= SQW'(px) * SQW'(px) + SQW'(py) * SQW'(py);
    sq_a_q  <= SQW'(qx) * SQW'(qx) + SQW'(qy) * SQW'(qy);
    sr_a_q  <= SQW'(rx) * SQW'(rx) + SQW'(ry) * SQW'(ry);
    st_a_q  <= SQW'(tx) * SQW'(tx) + SQW'(ty) * SQW'(ty);
  end

  // Stage B: determinant products and bisector constants.
  logic                  vb_q;
  logic signed [PW-1:0]  pd1_b_q, pd2_b_q;
  logic signed [CW-1:0]  c1_b_q, c2_b_q, e_b_q;
  logic signed [DXW-1:0] dx1_b_q, dy1_b_q, dx2_b_q, dy2_b_q, tpx_b_q, tpy_b_q;

  always_ff @(posedge clk_i) begin
    pd1_b_q <= PW'(dx1_a_q) * PW'(dy2_a_q);
    pd2_b_q <= PW'(dx2_a_q) * PW'(dy1_a_q);
    c1_b_q  <= CW'(sq_a_q) - CW'(sp_a_q);
    c2_b_q  <= CW'(sr_a_q) - CW'(sq_a_q);
    e_b_q   <= CW'(st_a_q) - CW'(sp_a_q);
    dx1_b_q <= dx1_a_q;
    dy1_b_q <= dy1_a_q;
    dx2_b_q <= dx2_a_q;
    dy2_b_q <= dy2_a_q;
    tpx_b_q <= tpx_a_q;
    tpy_b_q <= tpy_a_q;
  end

  // Stage C: determinant and numerator products.
  logic                   vc_q;
  logic signed [DETW-1:0] det_c_q;
  logic signed [NPW-1:0]  m1_c_q, m2_c_q, m3_c_q, m4_c_q;
  logic signed [CW-1:0]   e_c_q;
  logic signed [DXW-1:0]  tpx_c_q, tpy_c_q;

  always_ff @(posedge clk_i) begin
    det_c_q <= DETW'(pd1_b_q) - DETW'(pd2_b_q);
    m1_c_q  <= NPW'(dy2_b_q) * NPW'(c1_b_q);
    m2_c_q  <= NPW'(dy1_b_q) * NPW'(c2_b_q);
    m3_c_q  <= NPW'(dx1_b_q) * NPW'(c2_b_q);
    m4_c_q  <= NPW'(dx2_b_q) * NPW'(c1_b_q);
    e_c_q   <= e_b_q;
    tpx_c_q <= tpx_b_q;
    tpy_c_q <= tpy_b_q;
  end

  // Stage D: center numerators and scaled power difference.
  logic                   vd_q;
  logic signed [DENW-1:0] den_c;
  logic signed [NXW-1:0]  nx_d_q, ny_d_q;
  logic signed [DENW-1:0] den_d_q;
  logic signed [EPW-1:0]  ep_d_q;
  logic signed [DXW-1:0]  tpx_d_q, tpy_d_q;

  assign den_c = DENW'(det_c_q) <<< 1;

  always_ff @(posedge clk_i) begin
    nx_d_q  <= NXW'(m1_c_q) - NXW'(m2_c_q);
    ny_d_q  <= NXW'(m3_c_q) - NXW'(m4_c_q);
    den_d_q <= den_c;
    ep_d_q  <= EPW'(e_c_q) * EPW'(den_c);
    tpx_d_q <= tpx_c_q;
    tpy_d_q <= tpy_c_q;
  end

  // Stage E: query products, magnitudes and overflow checks.
  logic [NXW-1:0]        magx, magy;
  logic [NW-1:0]         nmx, nmy;
  logic [DENW-1:0]       dmag;
  logic                  ve_q;
  logic signed [TPW-1:0] t1_e_q, t2_e_q;
  logic signed [EPW-1:0] ep_e_q;
  logic [NW-1:0]         nmx_e_q, nmy_e_q;
  logic [DENW-1:0]       dm_e_q;
  logic                  negx_e_q, negy_e_q, ovfx_e_q, ovfy_e_q, col_e_q, dneg_e_q;

  always_comb begin
    magx = nx_d_q[NXW-1] ? NXW'(-nx_d_q) : NXW'(nx_d_q);
    magy = ny_d_q[NXW-1] ? NXW'(-ny_d_q) : NXW'(ny_d_q);
    nmx  = NW'(magx) << FRAC_BITS;
    nmy  = NW'(magy) << FRAC_BITS;
    dmag = den_d_q[DENW-1] ? DENW'(-den_d_q) : DENW'(den_d_q);
  end

  always_ff @(posedge clk_i) begin
    t1_e_q   <= TPW'(nx_d_q) * TPW'(tpx_d_q);
    t2_e_q   <= TPW'(ny_d_q) * TPW'(tpy_d_q);
    ep_e_q   <= ep_d_q;
    nmx_e_q  <= nmx;
    nmy_e_q  <= nmy;
    dm_e_q   <= dmag;
    negx_e_q <= nx_d_q[NXW-1] ^ den_d_q[DENW-1];
    negy_e_q <= ny_d_q[NXW-1] ^ den_d_q[DENW-1];
    ovfx_e_q <= OW'(nmx) >= (OW'(dmag) << QB);
    ovfy_e_q <= OW'(nmy) >= (OW'(dmag) << QB);
    col_e_q  <= den_d_q == '0;
    dneg_e_q <= den_d_q[DENW-1];
  end

  // Stage F: in-circle sign.
  logic signed [SW-1:0] ssum, sval;
  logic                 vf_q;
  div_side_t            side_f_q;
  logic [NW-1:0]        nmx_f_q, nmy_f_q;
  logic [DENW-1:0]      dm_f_q;

  always_comb begin
    ssum = SW'(t1_e_q) + SW'(t2_e_q);
    sval = SW'(ep_e_q) - (ssum <<< 1);
  end

  always_ff @(posedge clk_i) begin
    side_f_q.neg_x      <= negx_e_q;
    side_f_q.neg_y      <= negy_e_q;
    side_f_q.ovf_x      <= ovfx_e_q;
    side_f_q.ovf_y      <= ovfy_e_q;
    side_f_q.collinear  <= col_e_q;
    side_f_q.inside_res <= !col_e_q && (sval != '0) && (sval[SW-1] ^ dneg_e_q);
    nmx_f_q             <= nmx_e_q;
    nmy_f_q             <= nmy_e_q;
    dm_f_q              <= dm_e_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
    end else begin
      va_q <= in_acc;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
      vf_q <= ve_q;
    end
  end

  logic          vdiv;
  div_side_t     side_div;
  logic [QB-1:0] qx_div, qy_div;

  ccpt_div #(
    .NW(NW),
    .DW(DENW),
    .QB(QB)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vf_q),
    .side_i  (side_f_q),
    .nx_i    (nmx_f_q),
    .ny_i    (nmy_f_q),
    .d_i     (dm_f_q),
    .valid_o (vdiv),
    .side_o  (side_div),
    .qx_o    (qx_div),
    .qy_o    (qy_div)
  );

  // Saturation and output register.
  logic                sat_x, sat_y;
  logic [OUT_BITS-1:0] cx, cy;
  logic                res_valid_q;
  out_word_t           res_q;

  always_comb begin
    if (side_div.neg_x) begin
      sat_x = side_div.ovf_x || (qx_div > (QB'(1) << (OUT_BITS - 1)));
      cx    = sat_x ? (OUT_BITS'(1) << (OUT_BITS - 1)) : OUT_BITS'(-qx_div);
    end else begin
      sat_x = side_div.ovf_x || (qx_div[QB-1:OUT_BITS-1] != '0);
      cx    = sat_x ? ~(OUT_BITS'(1) << (OUT_BITS - 1)) : OUT_BITS'(qx_div);
    end
    if (side_div.neg_y) begin
      sat_y = side_div.ovf_y || (qy_div > (QB'(1) << (OUT_BITS - 1)));
      cy    = sat_y ? (OUT_BITS'(1) << (OUT_BITS - 1)) : OUT_BITS'(-qy_div);
    end else begin
      sat_y = side_div.ovf_y || (qy_div[QB-1:OUT_BITS-1] != '0);
      cy    = sat_y ? ~(OUT_BITS'(1) << (OUT_BITS - 1)) : OUT_BITS'(qy_div);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= vdiv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (side_div.collinear) begin
      res_q.center_x   <= '0;
      res_q.center_y   <= '0;
      res_q.inside_res <= 1'b0;
      res_q.collinear  <= 1'b1;
      res_q.saturated  <= 1'b0;
    end else begin
      res_q.center_x   <= cx;
      res_q.center_y   <= cy;
      res_q.inside_res <= side_div.inside_res;
      res_q.collinear  <= 1'b0;
      res_q.saturated  <= sat_x || sat_y;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
